// ----- hw/rtl/atsw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package atsw_pkg;

  localparam int unsigned SAMPLE_RATE_DEF = 48000;

  localparam int unsigned T_W     = 32;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned PH_W    = 8;
  localparam int unsigned HZ_W    = 11;
  localparam int unsigned CFG_W   = AMP_W;
  localparam int unsigned CFG_I_W = 1;

  localparam int unsigned STEPS   = T_W / 2;
  localparam int unsigned CNT_W   = $clog2(STEPS);

  localparam logic [AMP_W-1:0] AMP_RST = AMP_W'(8000);

  typedef enum logic [1:0] {
    PRESET_BEEP  = 2'd0,
    PRESET_BEEP2 = 2'd1,
    PRESET_CHIRP = 2'd2,
    PRESET_SIREN = 2'd3
  } preset_e;

  localparam logic [CFG_I_W-1:0] CFG_TONE_PRESET = 1'b0;
  localparam logic [CFG_I_W-1:0] CFG_AMPLITUDE   = 1'b1;

  localparam logic [HZ_W-1:0] BEEP_HZ     = HZ_W'(880);
  localparam logic [HZ_W-1:0] BEEP2_HZ    = HZ_W'(1100);
  localparam logic [HZ_W-1:0] CHIRP_HZ    = HZ_W'(600);
  localparam logic [HZ_W-1:0] SIREN_LO_HZ = HZ_W'(700);
  localparam logic [HZ_W-1:0] SIREN_HI_HZ = HZ_W'(1000);

  localparam logic [HZ_W-1:0] BEEP_ON     = HZ_W'(250);
  localparam logic [HZ_W-1:0] BEEP_CYC    = HZ_W'(500);
  localparam logic [HZ_W-1:0] BEEP2_ON    = HZ_W'(90);
  localparam logic [HZ_W-1:0] BEEP2_CYC   = HZ_W'(180);
  localparam logic [HZ_W-1:0] CHIRP_ON    = HZ_W'(400);
  localparam logic [HZ_W-1:0] CHIRP_CYC   = HZ_W'(600);
  localparam logic [HZ_W-1:0] SIREN_STEP  = HZ_W'(300);
  localparam logic [HZ_W-1:0] SIREN_CYC   = HZ_W'(600);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOD  = 5'b00010,
    ST_HZ   = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic load_div;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ringing;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/atsw_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface atsw_req_if;
  logic                      valid;
  logic                      ready;
  logic [atsw_pkg::T_W-1:0]  time_ms;
  logic                      ringing;

  modport source (output valid, output time_ms, output ringing, input ready);
  modport sink   (input valid, input time_ms, input ringing, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/atsw_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface atsw_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [atsw_pkg::SMP_W-1:0] sample_value;
  logic                             tone_gate;

  modport source (output valid, output sample_value, output tone_gate, input ready);
  modport sink   (input valid, input sample_value, input tone_gate, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/alarm_tone_square_wave_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Alarm tone square-wave generator: one result per sample request. A ringing
// request is handled in order: load, 16 radix-4 steps of the shared restoring
// divider for time_ms modulo the preset cycle, pick hz and the gate, 16 steps
// of the same divider for SAMPLE_RATE / hz, and write the output register. A
// request with ringing low skips the divider and the hz step. The divider sets
// the rate while the output is not stalled. A finished result waits in the
// output register while the next request is already taken in. Configuration
// (tone_preset at index 0, amplitude at index 1) is to be written by the user
// while the block is idle, which the block itself does not enforce; both apply from the next request.
module alarm_tone_square_wave_generator #(
  parameter int unsigned SAMPLE_RATE = atsw_pkg::SAMPLE_RATE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [atsw_pkg::CFG_I_W-1:0]      cfg_idx_i,
  input  wire [atsw_pkg::CFG_W-1:0]        cfg_data_i,
  atsw_req_if.sink                         req,
  atsw_res_if.source                       res
);

  atsw_pkg::preset_e             preset_q, preset_d;
  logic [atsw_pkg::AMP_W-1:0]    amp_q, amp_d;
  atsw_pkg::cmd_t                cmd;
  atsw_pkg::status_t             st;

  always_comb begin
    preset_d = preset_q;
    amp_d    = amp_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atsw_pkg::CFG_TONE_PRESET: preset_d = atsw_pkg::preset_e'(cfg_data_i[1:0]);
        atsw_pkg::CFG_AMPLITUDE:   amp_d    = cfg_data_i[atsw_pkg::AMP_W-1:0];
        default:                   amp_d    = amp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= atsw_pkg::PRESET_BEEP;
      amp_q    <= atsw_pkg::AMP_RST;
    end else begin
      preset_q <= preset_d;
      amp_q    <= amp_d;
    end
  end

  atsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  atsw_dpath #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .preset_i    (preset_q),
    .amp_i       (amp_q),
    .time_ms_i   (req.time_ms),
    .ringing_i   (req.ringing),
    .out_ready_i (res.ready),
    .out_valid_o (res.valid),
    .sample_o    (res.sample_value),
    .gate_o      (res.tone_gate)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/atsw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  atsw_pkg::status_t   st_i,
  output atsw_pkg::cmd_t      cmd_o
);

  atsw_pkg::state_e              state_q, state_d;
  logic [atsw_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          cnt_last;

  assign cnt_last   = (cnt_q == atsw_pkg::CNT_W'(atsw_pkg::STEPS - 1));
  assign in_ready_o = (state_q == atsw_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      atsw_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = atsw_pkg::ST_MOD;
        end
      end
      atsw_pkg::ST_MOD: begin
        if (!st_i.ringing) begin
          state_d = atsw_pkg::ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_last) begin
            state_d = atsw_pkg::ST_HZ;
          end
        end
      end
      atsw_pkg::ST_HZ: begin
        cmd_o.load_div = 1'b1;
        cnt_d          = '0;
        state_d        = atsw_pkg::ST_DIV;
      end
      atsw_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = atsw_pkg::ST_DONE;
        end
      end
      atsw_pkg::ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = atsw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atsw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atsw_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/atsw_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsw_dpath #(
  parameter int unsigned SAMPLE_RATE = atsw_pkg::SAMPLE_RATE_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  atsw_pkg::cmd_t                     cmd_i,
  output atsw_pkg::status_t                  st_o,
  input  atsw_pkg::preset_e                  preset_i,
  input  wire [atsw_pkg::AMP_W-1:0]          amp_i,
  input  wire [atsw_pkg::T_W-1:0]            time_ms_i,
  input  wire                                ringing_i,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic signed [atsw_pkg::SMP_W-1:0]  sample_o,
  output logic                               gate_o
);

  localparam int unsigned HZ_W  = atsw_pkg::HZ_W;
  localparam int unsigned T_W   = atsw_pkg::T_W;
  localparam int unsigned PH_W  = atsw_pkg::PH_W;
  localparam int unsigned SMP_W = atsw_pkg::SMP_W;

  logic [T_W-1:0]          dvd_q, dvd_d;
  logic [HZ_W-1:0]         rem_q, rem_d;
  logic [HZ_W-1:0]         dsr_q, dsr_d;
  logic                    gate_q, gate_d;
  logic                    ring_q, ring_d;
  logic                    active_q, active_d;
  logic [PH_W-1:0]         phase_q, phase_d;
  logic signed [SMP_W-1:0] sample_q, sample_d;
  logic                    tgate_q, tgate_d;
  logic                    ovalid_q, ovalid_d;

  logic [HZ_W:0]           r1, r2;
  logic                    q1, q2;
  logic [HZ_W-1:0]         cyc;
  logic [HZ_W-1:0]         hz;
  logic                    gate_c;
  logic [HZ_W:0]           ph3;
  logic [PH_W-1:0]         period;
  logic [PH_W-1:0]         ph_used;
  logic [PH_W:0]           ph_inc;
  logic                    sound;
  logic [SMP_W-1:0]        amp_ext;

  always_comb begin
    unique case (preset_i)
      atsw_pkg::PRESET_BEEP:  cyc = atsw_pkg::BEEP_CYC;
      atsw_pkg::PRESET_BEEP2: cyc = atsw_pkg::BEEP2_CYC;
      atsw_pkg::PRESET_CHIRP: cyc = atsw_pkg::CHIRP_CYC;
      atsw_pkg::PRESET_SIREN: cyc = atsw_pkg::SIREN_CYC;
      default:                cyc = atsw_pkg::BEEP_CYC;
    endcase
  end

  assign ph3 = {rem_q, 1'b0} + {1'b0, rem_q};

  always_comb begin
    unique case (preset_i)
      atsw_pkg::PRESET_BEEP: begin
        gate_c = (rem_q < atsw_pkg::BEEP_ON);
        hz     = atsw_pkg::BEEP_HZ;
      end
      atsw_pkg::PRESET_BEEP2: begin
        gate_c = (rem_q < atsw_pkg::BEEP2_ON);
        hz     = atsw_pkg::BEEP2_HZ;
      end
      atsw_pkg::PRESET_CHIRP: begin
        gate_c = (rem_q < atsw_pkg::CHIRP_ON);
        hz     = gate_c ? atsw_pkg::CHIRP_HZ + ph3[HZ_W:1] : atsw_pkg::CHIRP_HZ;
      end
      atsw_pkg::PRESET_SIREN: begin
        gate_c = 1'b1;
        hz     = (rem_q >= atsw_pkg::SIREN_STEP) ? atsw_pkg::SIREN_HI_HZ
                                                 : atsw_pkg::SIREN_LO_HZ;
      end
      default: begin
        gate_c = 1'b0;
        hz     = atsw_pkg::BEEP_HZ;
      end
    endcase
  end

  always_comb begin
    r1 = {rem_q, dvd_q[T_W-1]};
    q1 = (r1 >= {1'b0, dsr_q});
    if (q1) begin
      r1 = r1 - {1'b0, dsr_q};
    end
    r2 = {r1[HZ_W-1:0], dvd_q[T_W-2]};
    q2 = (r2 >= {1'b0, dsr_q});
    if (q2) begin
      r2 = r2 - {1'b0, dsr_q};
    end
  end

  assign period  = dvd_q[PH_W-1:0];
  assign ph_used = active_q ? phase_q : '0;
  assign ph_inc  = {1'b0, ph_used} + 1'b1;
  assign sound   = gate_q && (amp_i != '0) && (period != '0);
  assign amp_ext = {1'b0, amp_i};

  always_comb begin
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    gate_d   = gate_q;
    ring_d   = ring_q;
    active_d = active_q;
    phase_d  = phase_q;
    sample_d = sample_q;
    tgate_d  = tgate_q;
    ovalid_d = ovalid_q && !out_ready_i;
    priority if (cmd_i.load) begin
      dvd_d  = time_ms_i;
      rem_d  = '0;
      dsr_d  = cyc;
      ring_d = ringing_i;
    end else if (cmd_i.step) begin
      dvd_d = {dvd_q[T_W-3:0], q1, q2};
      rem_d = r2[HZ_W-1:0];
    end else if (cmd_i.load_div) begin
      dvd_d  = T_W'(SAMPLE_RATE);
      rem_d  = '0;
      dsr_d  = hz;
      gate_d = gate_c;
    end else if (cmd_i.finish) begin
      ovalid_d = 1'b1;
      if (!ring_q) begin
        active_d = 1'b0;
        sample_d = '0;
        tgate_d  = 1'b0;
      end else begin
        active_d = 1'b1;
        tgate_d  = gate_q;
        phase_d  = ph_used;
        sample_d = '0;
        if (sound) begin
          sample_d = (ph_used < (period >> 1)) ? $signed(amp_ext) : -$signed(amp_ext);
          phase_d  = (ph_inc >= {1'b0, period}) ? '0 : ph_inc[PH_W-1:0];
        end
      end
    end else begin
      dvd_d = dvd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    gate_q   <= gate_d;
    ring_q   <= ring_d;
    sample_q <= sample_d;
    tgate_q  <= tgate_d;
  end

  assign st_o.ringing  = ring_q;
  assign st_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o   = ovalid_q;
  assign sample_o      = sample_q;
  assign gate_o        = tgate_q;

endmodule

`default_nettype wire

// ----- hw/rtl/atsw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsw_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_i,
  input wire                       out_valid_i,
  input wire                       out_ready_i,
  input wire [atsw_pkg::SMP_W-1:0] sample_i,
  input wire                       gate_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i) && $stable(gate_i))
    else $error("result changed while stalled");

  a_silent_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !gate_i |-> sample_i == '0)
    else $error("nonzero sample with gate off");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  a_no_back_to_back_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 !in_ready_i)
    else $error("request taken before work finished");

endmodule

bind alarm_tone_square_wave_generator atsw_checker u_atsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req.valid),
  .in_ready_i  (req.ready),
  .out_valid_i (res.valid),
  .out_ready_i (res.ready),
  .sample_i    (res.sample_value),
  .gate_i      (res.tone_gate)
);

`default_nettype wire

// ----- sim/tb_alarm_tone_square_wave_generator.sv -----
`timescale 1ns / 1ps

module tb_alarm_tone_square_wave_generator;
  import atsw_pkg::*;

  localparam int unsigned RATE           = SAMPLE_RATE_DEF;
  localparam int unsigned RAND_ITEMS     = 1825;
  localparam int unsigned HOLDOFF_AT     = 700;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned N_ROWS         = 25;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_value;
    logic                    tone_gate;
  } tone_res_t;

  typedef struct packed {
    preset_e          preset;
    logic [AMP_W-1:0] amp;
    logic [T_W-1:0]   time_ms;
    logic             ringing;
    logic             typed;
    tone_res_t        want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_I_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  atsw_req_if req_if ();
  atsw_res_if res_if ();

  alarm_tone_square_wave_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .res        (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  preset_e          cur_preset = PRESET_BEEP;
  logic [AMP_W-1:0] cur_amp    = AMP_RST;
  logic             tone_on    = 1'b0;
  logic [PH_W-1:0]  phase_q    = '0;
  tone_res_t        tone_q[$];
  int unsigned      fail_cnt   = 0;
  int unsigned      idle_cycles = 0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{PRESET_BEEP,  15'd8000,  32'd0,          1'b0, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_BEEP,  15'd8000,  32'd0,          1'b1, 1'b1, '{16'sd8000,  1'b1}},
    '{PRESET_BEEP,  15'd8000,  32'd1,          1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_BEEP,  15'd8000,  32'd249,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_BEEP,  15'd8000,  32'd250,        1'b1, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_BEEP,  15'd8000,  32'd499,        1'b1, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_BEEP,  15'd8000,  32'hFFFF_FFFF,  1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_BEEP2, 15'd32767, 32'd0,          1'b0, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_BEEP2, 15'd32767, 32'd89,         1'b1, 1'b1, '{16'sd32767, 1'b1}},
    '{PRESET_BEEP2, 15'd32767, 32'd90,         1'b1, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_BEEP2, 15'd32767, 32'd179,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_BEEP2, 15'd32767, 32'd180,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_CHIRP, 15'd0,     32'd0,          1'b1, 1'b1, '{16'sd0,     1'b1}},
    '{PRESET_CHIRP, 15'd0,     32'd400,        1'b1, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_CHIRP, 15'd1,     32'd0,          1'b0, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_CHIRP, 15'd1,     32'd0,          1'b1, 1'b1, '{16'sd1,     1'b1}},
    '{PRESET_CHIRP, 15'd1,     32'd399,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_CHIRP, 15'd1,     32'd599,        1'b1, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_CHIRP, 15'd1,     32'd600,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'd0,          1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'd299,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'd300,        1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'hFFFF_FFFF,  1'b1, 1'b0, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'd0,          1'b0, 1'b1, '{16'sd0,     1'b0}},
    '{PRESET_SIREN, 15'd32767, 32'd600,        1'b1, 1'b1, '{16'sd32767, 1'b1}}
  };

  function automatic void tone_shape(input logic [T_W-1:0] t, output int unsigned period,
                                     output logic gate);
    int unsigned hz;
    int unsigned pos;
    hz   = 0;
    pos  = 0;
    gate = 1'b1;
    case (cur_preset)
      PRESET_BEEP: begin
        pos  = t % BEEP_CYC;
        gate = pos < BEEP_ON;
        hz   = BEEP_HZ;
      end
      PRESET_BEEP2: begin
        pos  = t % BEEP2_CYC;
        gate = pos < BEEP2_ON;
        hz   = BEEP2_HZ;
      end
      PRESET_CHIRP: begin
        pos  = t % CHIRP_CYC;
        gate = pos < CHIRP_ON;
        hz   = CHIRP_HZ;
        if (gate) begin
          hz = CHIRP_HZ + (CHIRP_HZ * pos) / CHIRP_ON;
        end
      end
      default: begin
        hz = ((t / SIREN_STEP) % 2 == 1) ? SIREN_HI_HZ : SIREN_LO_HZ;
      end
    endcase
    period = RATE / hz;
  endfunction

  function automatic tone_res_t next_tone(input logic [T_W-1:0] t, input logic ringing);
    tone_res_t               r;
    int unsigned             period;
    logic                    gate;
    logic signed [SMP_W-1:0] mag;
    r = '0;
    if (!ringing) begin
      tone_on = 1'b0;
    end else begin
      if (!tone_on) begin
        tone_on = 1'b1;
        phase_q = '0;
      end
      tone_shape(t, period, gate);
      r.tone_gate = gate;
      if (gate && cur_amp != 0 && period != 0) begin
        mag = {1'b0, cur_amp};
        r.sample_value = (phase_q < period / 2) ? mag : -mag;
        if (int'(phase_q) + 1 >= period) begin
          phase_q = '0;
        end else begin
          phase_q = phase_q + 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_tone_req(input logic [T_W-1:0] t, input logic ringing, input logic typed,
                               input tone_res_t want, input int unsigned gap);
    tone_res_t predicted;
    req_if.valid   <= 1'b1;
    req_if.time_ms <= t;
    req_if.ringing <= ringing;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = next_tone(t, ringing);
    tone_q.push_back(typed ? want : predicted);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain all outstanding results before touching the registers
  task automatic write_tone_cfg(input preset_e preset, input logic [AMP_W-1:0] amp);
    req_if.valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TONE_PRESET;
    cfg_data_i <= CFG_W'(preset);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_AMPLITUDE;
    cfg_data_i <= amp;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_preset = preset;
    cur_amp    = amp;
  endtask

  initial begin
    tone_res_t        none;
    preset_e          preset;
    logic [AMP_W-1:0] amp;
    logic [T_W-1:0]   t;
    logic             ring;
    int unsigned      sent;
    int unsigned      n_phase;
    int unsigned      gap_max;
    int unsigned      r;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    req_if.valid   <= 1'b0;
    req_if.time_ms <= '0;
    req_if.ringing <= 1'b0;
    none = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].preset != cur_preset || dir_rows[i].amp != cur_amp) begin
        write_tone_cfg(dir_rows[i].preset, dir_rows[i].amp);
      end
      send_tone_req(dir_rows[i].time_ms, dir_rows[i].ringing, dir_rows[i].typed,
                    dir_rows[i].want, $urandom_range(0, 19));
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      preset = preset_e'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       amp = '0;
        1:       amp = '1;
        2:       amp = AMP_W'(1);
        default: amp = AMP_W'($urandom);
      endcase
      write_tone_cfg(preset, amp);
      case ($urandom_range(0, 3))
        0:       t = '1 - $urandom_range(0, 3000);
        1:       t = $urandom_range(0, 1000);
        default: t = $urandom;
      endcase
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      n_phase = $urandom_range(40, 80);
      repeat (n_phase) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          t    = $urandom;
          ring = $urandom_range(0, 1);
        end else if (r == 1) begin
          ring = 1'b0;
        end else begin
          ring = 1'b1;
          t += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(0, 1);
        end
        send_tone_req(t, ring, 1'b0, none, $urandom_range(0, gap_max));
        sent++;
      end
    end

    req_if.valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned n_res;
    int unsigned stall;
    logic        calm;
    tone_res_t   want;
    n_res = 0;
    calm  = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      n_res++;
      if (tone_q.size() == 0) begin
        $error("unexpected result: sample_value %0d tone_gate %0b",
               res_if.sample_value, res_if.tone_gate);
        fail_cnt++;
      end else begin
        want = tone_q.pop_front();
        if (res_if.sample_value !== want.sample_value) begin
          $error("sample_value: expected %0d, got %0d", want.sample_value, res_if.sample_value);
          fail_cnt++;
        end
        if (res_if.tone_gate !== want.tone_gate) begin
          $error("tone_gate: expected %0b, got %0b", want.tone_gate, res_if.tone_gate);
          fail_cnt++;
        end
      end
      if (n_res % 64 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      stall = calm ? 0 : $urandom_range(0, 19);
      // hold off long enough for the block to fill and stall its input
      if (n_res == HOLDOFF_AT) begin
        stall = HOLDOFF_CYCLES;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/atsw_pkg.sv
hw/rtl/atsw_req_if.sv
hw/rtl/atsw_res_if.sv
hw/rtl/atsw_ctrl.sv
hw/rtl/atsw_dpath.sv
hw/rtl/alarm_tone_square_wave_generator.sv
hw/rtl/atsw_checker.sv
sim/tb_alarm_tone_square_wave_generator.sv
